@@ src/fuzzy_membership_evaluator_defines.svh @@
// Assertion macros shared by the fuzzy membership evaluator RTL.
`ifndef FUZZY_MEMBERSHIP_EVALUATOR_DEFINES_SVH
`define FUZZY_MEMBERSHIP_EVALUATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define FME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FME_ASSERT(lbl, clk, rst_n, prop, msg)
`define FME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ src/fme_pkg.sv @@
// Shared types and constants of the fuzzy membership evaluator.
`timescale 1ns / 1ps
package fme_pkg;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 15;
    localparam int DEG_WIDTH  = 16;
    localparam int IDX_WIDTH  = 3;
    localparam int QUOT_BITS  = FRAC_BITS + 1;
    localparam logic [DEG_WIDTH-1:0] UNITY = DEG_WIDTH'(1) << FRAC_BITS;

    // Shape codes
    localparam logic [2:0] SHAPE_TRI  = 3'd0;
    localparam logic [2:0] SHAPE_TRAP = 3'd1;
    localparam logic [2:0] SHAPE_Z    = 3'd2;
    localparam logic [2:0] SHAPE_S    = 3'd3;
    localparam logic [2:0] SHAPE_PI   = 3'd4;

    // Register indexes
    localparam logic [IDX_WIDTH-1:0] REG_SHAPE = 3'd0;
    localparam logic [IDX_WIDTH-1:0] REG_BRK_A = 3'd1;
    localparam logic [IDX_WIDTH-1:0] REG_BRK_B = 3'd2;
    localparam logic [IDX_WIDTH-1:0] REG_BRK_C = 3'd3;
    localparam logic [IDX_WIDTH-1:0] REG_BRK_D = 3'd4;

    // How the back end turns the ramp ratio into a degree
    localparam logic [2:0] MODE_ZERO   = 3'd0;
    localparam logic [2:0] MODE_ONE    = 3'd1;
    localparam logic [2:0] MODE_RAMP   = 3'd2;
    localparam logic [2:0] MODE_SQ     = 3'd3;
    localparam logic [2:0] MODE_ONE_SQ = 3'd4;

    typedef struct packed {
        logic [2:0]            mode;
        logic                  bad;
        logic [DATA_WIDTH-1:0] num;
        logic [DATA_WIDTH-1:0] den;
    } t_item;
endpackage

@@ src/fuzzy_membership_evaluator.sv @@
// Top level of the fuzzy membership evaluator.
`timescale 1ns / 1ps
// Evaluates the membership degree of each signed 16-bit sample in a fuzzy set
// that is triangular, trapezoidal, Z, S or Pi shaped, set by up to four
// breakpoints. Samples arrive as words on the slave stream; each gives one
// word on the master stream with the Q1.15 degree in tdata and the flag for
// misordered breakpoints or an unknown shape in tuser. The configuration
// channel writes the shape (index 0) and the breakpoints a to d (indexes 1
// to 4); it is always ready and should be used only while no words are in
// flight. Writes to other indexes are dropped. A sample passes from
// acceptance to its result word through the classification register, the
// queue, the sixteen-stage divider (one quotient bit per stage), the squaring
// multiplier and the output register. While the receiver takes words, one
// word is accepted every cycle and the divider starts a new ramp each cycle.
// Synchronous active-low reset empties the pipeline and the queue and sets
// all configuration registers to zero (triangular shape). When the receiver
// stalls, the back end holds, the two-entry queue fills and the front end
// then stops accepting samples; nothing is lost.
module fuzzy_membership_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fme_pkg::IDX_WIDTH-1:0]       i_cfg_index,
    input  logic [fme_pkg::DATA_WIDTH-1:0]      i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [fme_pkg::DATA_WIDTH-1:0]      i_s_axis_tdata,  // [15:0] sample
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [fme_pkg::DEG_WIDTH-1:0]       o_m_axis_tdata,  // [15:0] degree
    output logic                                o_m_axis_tuser   // [0] params_bad
);
    import fme_pkg::*;

    logic  fr_valid, q_full, q_valid, bk_pop;
    t_item fr_item, q_item;

    assign o_cfg_ready = 1'b1;

    fme_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_sample    (i_s_axis_tdata),
        .o_valid     (fr_valid),
        .i_ready     (!q_full),
        .o_item      (fr_item)
    );

    fme_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (bk_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    fme_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (bk_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_degree (o_m_axis_tdata),
        .o_bad    (o_m_axis_tuser)
    );
endmodule

@@ src/fme_front.sv @@
// Front end: configuration registers and classification of each sample.
`timescale 1ns / 1ps
module fme_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [fme_pkg::IDX_WIDTH-1:0]    i_cfg_index,
    input  logic [fme_pkg::DATA_WIDTH-1:0]   i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [fme_pkg::DATA_WIDTH-1:0] i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output fme_pkg::t_item                   o_item
);
    import fme_pkg::*;

    localparam int W1 = DATA_WIDTH + 1;
    localparam int W2 = DATA_WIDTH + 2;

    logic [2:0]                   r_shape;
    logic signed [DATA_WIDTH-1:0] r_a, r_b, r_c, r_d;
    logic                         r_valid;
    t_item                        r_item;
    t_item                        n_item;
    logic signed [W1-1:0] xa, bx, ba, cx, cb, dx, dc, xc;
    logic                 mab, mcd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_TRI;
            r_a <= '0;
            r_b <= '0;
            r_c <= '0;
            r_d <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SHAPE: r_shape <= i_cfg_data[2:0];
                REG_BRK_A: r_a <= i_cfg_data;
                REG_BRK_B: r_b <= i_cfg_data;
                REG_BRK_C: r_c <= i_cfg_data;
                REG_BRK_D: r_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        xa  = W1'(i_sample) - W1'(r_a);
        bx  = W1'(r_b) - W1'(i_sample);
        ba  = W1'(r_b) - W1'(r_a);
        cx  = W1'(r_c) - W1'(i_sample);
        cb  = W1'(r_c) - W1'(r_b);
        dx  = W1'(r_d) - W1'(i_sample);
        dc  = W1'(r_d) - W1'(r_c);
        xc  = W1'(i_sample) - W1'(r_c);
        mab = (W2'(i_sample) <<< 1) <= (W2'(r_a) + W2'(r_b));
        mcd = (W2'(i_sample) <<< 1) <= (W2'(r_c) + W2'(r_d));
    end

    // Works out which ramp feeds the divider and what to do with its ratio.
    always_comb begin
        n_item = '{mode: MODE_ZERO, bad: 1'b0, num: '0, den: '0};
        case (r_shape)
            SHAPE_TRI: begin
                if (r_a >= r_b || r_b >= r_c) n_item.bad = 1'b1;
                else if (i_sample <= r_a || i_sample >= r_c) n_item.mode = MODE_ZERO;
                else if (i_sample <= r_b) begin
                    n_item = '{MODE_RAMP, 1'b0, xa[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end else begin
                    n_item = '{MODE_RAMP, 1'b0, cx[DATA_WIDTH-1:0], cb[DATA_WIDTH-1:0]};
                end
            end
            SHAPE_TRAP: begin
                if (r_a >= r_b || r_b > r_c || r_c >= r_d) n_item.bad = 1'b1;
                else if (i_sample <= r_a || i_sample >= r_d) n_item.mode = MODE_ZERO;
                else if (i_sample <= r_b) begin
                    n_item = '{MODE_RAMP, 1'b0, xa[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end else if (i_sample <= r_c) n_item.mode = MODE_ONE;
                else begin
                    n_item = '{MODE_RAMP, 1'b0, dx[DATA_WIDTH-1:0], dc[DATA_WIDTH-1:0]};
                end
            end
            SHAPE_Z: begin
                if (r_a >= r_b) n_item.bad = 1'b1;
                else if (i_sample <= r_a) n_item.mode = MODE_ONE;
                else if (i_sample >= r_b) n_item.mode = MODE_ZERO;
                else if (mab) begin
                    n_item = '{MODE_ONE_SQ, 1'b0, xa[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end else begin
                    n_item = '{MODE_SQ, 1'b0, bx[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end
            end
            SHAPE_S: begin
                if (r_a >= r_b) n_item.bad = 1'b1;
                else if (i_sample <= r_a) n_item.mode = MODE_ZERO;
                else if (i_sample >= r_b) n_item.mode = MODE_ONE;
                else if (mab) begin
                    n_item = '{MODE_SQ, 1'b0, xa[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end else begin
                    n_item = '{MODE_ONE_SQ, 1'b0, bx[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end
            end
            SHAPE_PI: begin
                if (r_a >= r_b || r_b >= r_c || r_c >= r_d) n_item.bad = 1'b1;
                else if (i_sample <= r_a || i_sample >= r_d) n_item.mode = MODE_ZERO;
                else if (i_sample < r_b) begin
                    if (mab) n_item = '{MODE_SQ, 1'b0, xa[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                    else n_item = '{MODE_ONE_SQ, 1'b0, bx[DATA_WIDTH-1:0], ba[DATA_WIDTH-1:0]};
                end else if (i_sample <= r_c) n_item.mode = MODE_ONE;
                else if (mcd) begin
                    n_item = '{MODE_ONE_SQ, 1'b0, xc[DATA_WIDTH-1:0], dc[DATA_WIDTH-1:0]};
                end else begin
                    n_item = '{MODE_SQ, 1'b0, dx[DATA_WIDTH-1:0], dc[DATA_WIDTH-1:0]};
                end
            end
            default: n_item.bad = 1'b1;
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

@@ src/fme_queue.sv @@
// Two-entry queue between the classifying front end and the arithmetic back end.
`timescale 1ns / 1ps
`include "fuzzy_membership_evaluator_defines.svh"
module fme_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fme_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output fme_pkg::t_item o_item
);
    import fme_pkg::*;

    t_item      r_mem [0:1];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    logic       do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) r_wptr <= !r_wptr;
            if (do_pop)  r_rptr <= !r_rptr;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    `FME_ASSERT(a_count_range, i_clk, i_rst_n, r_count != 2'd3, "queue count out of range")
    `FME_ASSERT(a_fill, i_clk, i_rst_n, (do_push && !do_pop) |=> (r_count == $past(r_count) + 2'd1), "queue fill lost")
    `FME_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_count == 2'd1) |-> (r_wptr != r_rptr), "queue pointers disagree with count")
endmodule

@@ src/fme_back.sv @@
// Back end: pipelined ramp divider, squaring stage and output register.
`timescale 1ns / 1ps
`include "fuzzy_membership_evaluator_defines.svh"
module fme_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  fme_pkg::t_item                 i_item,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [fme_pkg::DEG_WIDTH-1:0]  o_degree,
    output logic                           o_bad
);
    import fme_pkg::*;

    localparam int NS = QUOT_BITS;
    localparam int PW = 2 * DEG_WIDTH;

    logic                  r_vld  [0:NS-1];
    logic [DATA_WIDTH-1:0] r_rem  [0:NS-1];
    logic [DATA_WIDTH-1:0] r_den  [0:NS-1];
    logic [DEG_WIDTH-1:0]  r_quo  [0:NS-1];
    logic [2:0]            r_mode [0:NS-1];
    logic                  r_bad  [0:NS-1];
    logic [DATA_WIDTH-1:0] n_rem  [0:NS-1];
    logic [DEG_WIDTH-1:0]  n_quo  [0:NS-1];

    logic                 r_pv, r_pbad;
    logic [2:0]           r_pmode;
    logic [DEG_WIDTH-1:0] r_pt;
    logic [PW-1:0]        r_prod;
    logic                 r_ov, r_obad;
    logic [DEG_WIDTH-1:0] r_odeg;
    logic [DEG_WIDTH-1:0] n_odeg;
    logic [DEG_WIDTH:0]   sq;
    logic                 en;

    // The whole pipeline moves when the output register is free or drained.
    assign en    = !r_ov || i_ready;
    assign o_pop = en;

    // One quotient bit per stage; the first stage handles a ratio of exactly one.
    always_comb begin
        logic [DATA_WIDTH:0] trial;
        trial = {1'b0, i_item.num};
        if (trial >= {1'b0, i_item.den}) begin
            n_rem[0] = DATA_WIDTH'(trial - {1'b0, i_item.den});
            n_quo[0] = DEG_WIDTH'(1);
        end else begin
            n_rem[0] = DATA_WIDTH'(trial);
            n_quo[0] = '0;
        end
        for (int s = 1; s < NS; s++) begin
            trial = {r_rem[s-1], 1'b0};
            if (trial >= {1'b0, r_den[s-1]}) begin
                n_rem[s] = DATA_WIDTH'(trial - {1'b0, r_den[s-1]});
                n_quo[s] = {r_quo[s-1][DEG_WIDTH-2:0], 1'b1};
            end else begin
                n_rem[s] = DATA_WIDTH'(trial);
                n_quo[s] = {r_quo[s-1][DEG_WIDTH-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) r_vld[s] <= 1'b0;
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < NS; s++) r_vld[s] <= r_vld[s-1];
            r_pv <= r_vld[NS-1];
            r_ov <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int s = 0; s < NS; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
            end
            r_den[0]  <= i_item.den;
            r_mode[0] <= i_item.mode;
            r_bad[0]  <= i_item.bad;
            for (int s = 1; s < NS; s++) begin
                r_den[s]  <= r_den[s-1];
                r_mode[s] <= r_mode[s-1];
                r_bad[s]  <= r_bad[s-1];
            end
            r_pt    <= r_quo[NS-1];
            r_prod  <= r_quo[NS-1] * r_quo[NS-1];
            r_pmode <= r_mode[NS-1];
            r_pbad  <= r_bad[NS-1];
            r_odeg  <= n_odeg;
            r_obad  <= r_pbad;
        end
    end

    // Twice the square in Q15 is the product shifted down by one bit less.
    assign sq = r_prod[FRAC_BITS-1 +: DEG_WIDTH+1];

    always_comb begin
        unique case (r_pmode)
            MODE_ZERO:   n_odeg = '0;
            MODE_ONE:    n_odeg = UNITY;
            MODE_RAMP:   n_odeg = r_pt;
            MODE_SQ:     n_odeg = sq[DEG_WIDTH-1:0];
            MODE_ONE_SQ: n_odeg = DEG_WIDTH'({1'b0, UNITY} - sq);
            default:     n_odeg = '0;
        endcase
        if (r_pbad) n_odeg = '0;
    end

    assign o_valid  = r_ov;
    assign o_degree = r_odeg;
    assign o_bad    = r_obad;

    `FME_ASSERT(a_bad_zero, i_clk, i_rst_n, (r_ov && r_obad) |-> (r_odeg == '0), "flagged word carries a degree")
    `FME_ASSERT(a_deg_max, i_clk, i_rst_n, r_ov |-> (r_odeg <= UNITY), "degree above one")
    `FME_ASSERT(a_hold, i_clk, i_rst_n, !en |=> $stable(r_vld[NS-1]), "divider moved while stalled")
endmodule
